>>> design/hmbt_pkg.sv
// ----------------------------------------------------------------------------
// hmbt_pkg
// shared types and constants for the handheld memory bus with timer
// ----------------------------------------------------------------------------
package hmbt_pkg;

	localparam int ROM_BYTES  = 32768;
	localparam int VRAM_BYTES = 8192;
	localparam int ERAM_BYTES = 8192;
	localparam int WRAM_BYTES = 8192;
	localparam int OAM_BYTES  = 160;
	localparam int HRAM_BYTES = 127;

	localparam int ROM_AW  = $clog2(ROM_BYTES);
	localparam int VRAM_AW = $clog2(VRAM_BYTES);
	localparam int ERAM_AW = $clog2(ERAM_BYTES);
	localparam int WRAM_AW = $clog2(WRAM_BYTES);
	localparam int OAM_AW  = $clog2(OAM_BYTES);
	localparam int IO_AW   = 7;
	localparam int HRAM_AW = $clog2(HRAM_BYTES);

	// memory identifiers for the address decode
	typedef enum logic [3:0] {
		MEM_ROM, MEM_VRAM, MEM_ERAM, MEM_WRAM, MEM_OAM,
		MEM_IO, MEM_HRAM, MEM_IE, MEM_NONE
	} mem_sel_t;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_DMA_RD, ST_DMA_WR,
		ST_TICK_RD, ST_TICK_STEP, ST_TICK_WR, ST_DONE
	} state_t;

	localparam logic [15:0] DIV_ADDR = 16'hFF04;
	localparam logic [15:0] DMA_ADDR = 16'hFF46;
	localparam logic [7:0]  DMA_LEN  = 8'hA0;

	localparam logic [IO_AW-1:0] IO_JOYP = 7'h00;
	localparam logic [IO_AW-1:0] IO_DIV  = 7'h04;
	localparam logic [IO_AW-1:0] IO_TIMA = 7'h05;
	localparam logic [IO_AW-1:0] IO_TMA  = 7'h06;
	localparam logic [IO_AW-1:0] IO_TAC  = 7'h07;
	localparam logic [IO_AW-1:0] IO_IF   = 7'h0F;
	localparam logic [IO_AW-1:0] IO_LCDC = 7'h40;
	localparam logic [IO_AW-1:0] IO_BGP  = 7'h47;
	localparam logic [IO_AW-1:0] IO_OBP0 = 7'h48;
	localparam logic [IO_AW-1:0] IO_OBP1 = 7'h49;

	// post-boot value of an I/O register
	function automatic logic [7:0] io_reset_value(input logic [IO_AW-1:0] a);
		logic [7:0] v;
		v = 8'h00;
		if (a == IO_JOYP || a == IO_OBP0 || a == IO_OBP1) v = 8'hFF;
		if (a == IO_LCDC) v = 8'h93;
		if (a == IO_BGP)  v = 8'hFC;
		if (a == IO_IF)   v = 8'hE1;
		return v;
	endfunction

	typedef struct packed {
		mem_sel_t       sel;
		logic [14:0]    offset;
	} decode_t;

	function automatic decode_t decode(input logic [15:0] a);
		decode_t d;
		d.offset = 15'd0;
		d.sel    = MEM_NONE;
		if (a <= 16'h7FFF) begin
			d.sel = MEM_ROM;  d.offset = a[14:0];
		end else if (a <= 16'h9FFF) begin
			d.sel = MEM_VRAM; d.offset = {2'b00, a[12:0]};
		end else if (a <= 16'hBFFF) begin
			d.sel = MEM_ERAM; d.offset = {2'b00, a[12:0]};
		end else if (a <= 16'hFDFF) begin
			d.sel = MEM_WRAM; d.offset = {2'b00, a[12:0]};
		end else if (a <= 16'hFE9F) begin
			d.sel = MEM_OAM;  d.offset = {7'd0, a[7:0]};
		end else if (a <= 16'hFEFF) begin
			d.sel = MEM_NONE;
		end else if (a <= 16'hFF7F) begin
			d.sel = MEM_IO;   d.offset = {8'd0, a[6:0]};
		end else if (a <= 16'hFFFE) begin
			d.sel = MEM_HRAM; d.offset = {8'd0, a[6:0]};
		end else begin
			d.sel = MEM_IE;
		end
		return d;
	endfunction

	// memory port request from the controller
	typedef struct packed {
		mem_sel_t       rd_sel;
		logic [14:0]    rd_addr;
		mem_sel_t       wr_sel;
		logic [14:0]    wr_addr;
		logic [7:0]     wr_data;
		logic           wr_en;
	} mem_req_t;

endpackage

>>> design/hmbt_ram.sv
// ----------------------------------------------------------------------------
// hmbt_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module hmbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> design/hmbt_mem.sv
// ----------------------------------------------------------------------------
// hmbt_mem
// bank of address-mapped memories with one read and one write port
// ----------------------------------------------------------------------------
module hmbt_mem
	import hmbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mem_req_t    req,
	input  logic        clear,
	input  logic [14:0] clr_addr,
	input  logic [7:0]  clr_io_data,
	output logic [7:0]  rdata
);

	logic [7:0]  rom_q, vram_q, eram_q, wram_q, oam_q, io_q, hram_q;
	logic [7:0]  ie_q, ie_rd_s1;
	mem_sel_t    sel_s1;
	logic        rom_we, vram_we, eram_we, wram_we, oam_we, io_we, hram_we;
	logic [14:0] waddr;
	logic [7:0]  wdata, io_wdata;

	// during the clearing pass each ram is written at the same index while that index is within its depth
	always_comb begin
		waddr    = clear ? clr_addr : req.wr_addr;
		wdata    = clear ? 8'h00 : req.wr_data;
		io_wdata = clear ? clr_io_data : req.wr_data;
		if (clear) begin
			rom_we  = 1'b1;
			vram_we = clr_addr < 15'(VRAM_BYTES);
			eram_we = clr_addr < 15'(ERAM_BYTES);
			wram_we = clr_addr < 15'(WRAM_BYTES);
			oam_we  = clr_addr < 15'(OAM_BYTES);
			io_we   = clr_addr < 15'd128;
			hram_we = clr_addr < 15'(HRAM_BYTES);
		end else begin
			rom_we  = req.wr_en && req.wr_sel == MEM_ROM;
			vram_we = req.wr_en && req.wr_sel == MEM_VRAM;
			eram_we = req.wr_en && req.wr_sel == MEM_ERAM;
			wram_we = req.wr_en && req.wr_sel == MEM_WRAM;
			oam_we  = req.wr_en && req.wr_sel == MEM_OAM;
			io_we   = req.wr_en && req.wr_sel == MEM_IO;
			hram_we = req.wr_en && req.wr_sel == MEM_HRAM;
		end
	end

	hmbt_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom (.clk(clk),
		.we(rom_we), .waddr(waddr[ROM_AW-1:0]),
		.wdata(wdata), .raddr(req.rd_addr[ROM_AW-1:0]), .rdata(rom_q));
	hmbt_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram (.clk(clk),
		.we(vram_we), .waddr(waddr[VRAM_AW-1:0]),
		.wdata(wdata), .raddr(req.rd_addr[VRAM_AW-1:0]), .rdata(vram_q));
	hmbt_ram #(.WIDTH(8), .DEPTH(ERAM_BYTES)) u_eram (.clk(clk),
		.we(eram_we), .waddr(waddr[ERAM_AW-1:0]),
		.wdata(wdata), .raddr(req.rd_addr[ERAM_AW-1:0]), .rdata(eram_q));
	hmbt_ram #(.WIDTH(8), .DEPTH(WRAM_BYTES)) u_wram (.clk(clk),
		.we(wram_we), .waddr(waddr[WRAM_AW-1:0]),
		.wdata(wdata), .raddr(req.rd_addr[WRAM_AW-1:0]), .rdata(wram_q));
	hmbt_ram #(.WIDTH(8), .DEPTH(OAM_BYTES)) u_oam (.clk(clk),
		.we(oam_we), .waddr(waddr[OAM_AW-1:0]),
		.wdata(wdata), .raddr(req.rd_addr[OAM_AW-1:0]), .rdata(oam_q));
	hmbt_ram #(.WIDTH(8), .DEPTH(128)) u_io (.clk(clk),
		.we(io_we), .waddr(waddr[IO_AW-1:0]),
		.wdata(io_wdata), .raddr(req.rd_addr[IO_AW-1:0]), .rdata(io_q));
	hmbt_ram #(.WIDTH(8), .DEPTH(HRAM_BYTES)) u_hram (.clk(clk),
		.we(hram_we), .waddr(waddr[HRAM_AW-1:0]),
		.wdata(wdata), .raddr(req.rd_addr[HRAM_AW-1:0]), .rdata(hram_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ie_q   <= 8'h00;
			sel_s1 <= MEM_NONE;
		end else begin
			if (req.wr_en && req.wr_sel == MEM_IE) ie_q <= req.wr_data;
			sel_s1 <= req.rd_sel;
		end
	end

	always_ff @(posedge clk) begin
		ie_rd_s1 <= ie_q;
	end

	always_comb begin
		unique case (sel_s1)
			MEM_ROM:  rdata = rom_q;
			MEM_VRAM: rdata = vram_q;
			MEM_ERAM: rdata = eram_q;
			MEM_WRAM: rdata = wram_q;
			MEM_OAM:  rdata = oam_q;
			MEM_IO:   rdata = io_q;
			MEM_HRAM: rdata = hram_q;
			MEM_IE:   rdata = ie_rd_s1;
			default:  rdata = 8'hFF;
		endcase
	end

endmodule

>>> design/hmbt_ctrl.sv
// ----------------------------------------------------------------------------
// hmbt_ctrl
// sequencer: clearing pass, bus access, rom load, sprite dma copy and timer update
// ----------------------------------------------------------------------------
module hmbt_ctrl
	import hmbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clearing,
	input  logic        start,
	input  logic [1:0]  op,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  logic [5:0]  cycles,
	output logic        busy,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        timer_irq_pending,
	output mem_req_t    req,
	input  logic [7:0]  rdata
);

	state_t      state_q, state_d;
	logic [14:0] cnt_q, cnt_d;
	logic [7:0]  data_q;
	logic [5:0]  cyc_q;
	logic [7:0]  div_cnt_q, div_cnt_d;
	logic [10:0] tim_cnt_q, tim_cnt_d;
	logic [7:0]  div_q, div_d, tima_q, tima_d, tma_q, tac_q, if_q, if_d;
	logic [7:0]  rd_q, rd_d;
	logic        irq_q;
	logic [7:0]  tac_d, tma_d;
	logic [10:0] period;
	logic [8:0]  div_sum;
	logic [10:0] tim_sum;
	decode_t     dec;

	// timer registers are shadowed here; the io ram keeps a copy for reads
	assign dec = decode(address);

	always_comb begin
		unique case (tac_q[1:0])
			2'd1:    period = 11'd16;
			2'd2:    period = 11'd64;
			2'd3:    period = 11'd256;
			default: period = 11'd1024;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			div_cnt_q <= '0;
			tim_cnt_q <= '0;
			div_q     <= 8'h00;
			tima_q    <= 8'h00;
			tma_q     <= 8'h00;
			tac_q     <= 8'h00;
			if_q      <= 8'hE1;
			irq_q     <= 1'b0;
			rd_q      <= 8'h00;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			div_cnt_q <= div_cnt_d;
			tim_cnt_q <= tim_cnt_d;
			div_q     <= div_d;
			tima_q    <= tima_d;
			tma_q     <= tma_d;
			tac_q     <= tac_d;
			if_q      <= if_d;
			rd_q      <= rd_d;
			irq_q     <= if_d[2];
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			data_q <= data;
			cyc_q  <= cycles;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		div_cnt_d = div_cnt_q;
		tim_cnt_d = tim_cnt_q;
		div_d     = div_q;
		tima_d    = tima_q;
		tma_d     = tma_q;
		tac_d     = tac_q;
		if_d      = if_q;
		rd_d      = rd_q;
		req       = '{rd_sel: MEM_NONE, rd_addr: '0, wr_sel: MEM_NONE,
			wr_addr: '0, wr_data: 8'h00, wr_en: 1'b0};
		div_sum   = {1'b0, div_cnt_q} + {3'd0, cyc_q};
		tim_sum   = tim_cnt_q + {5'd0, cyc_q};
		busy      = 1'b1;
		done      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				// the clearing pass owns the ram write ports
				if (!clearing) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				rd_d = 8'h00;
				if (start) begin
					unique case (op_t'(op))
						OP_READ: begin
							req.rd_sel  = dec.sel;
							req.rd_addr = dec.offset;
							state_d     = ST_READ;
						end
						OP_WRITE: begin
							req.wr_sel  = dec.sel;
							req.wr_addr = dec.offset;
							req.wr_data = data;
							req.wr_en   = dec.sel != MEM_ROM && dec.sel != MEM_NONE
								&& !(dec.sel == MEM_OAM && dec.offset >= 15'(OAM_BYTES))
								&& !(dec.sel == MEM_HRAM && dec.offset >= 15'(HRAM_BYTES));
							state_d     = ST_DONE;
							if (address == DIV_ADDR) begin
								req.wr_data = 8'h00;
								div_d       = 8'h00;
								div_cnt_d   = 8'h00;
							end else if (dec.sel == MEM_IO) begin
								if (dec.offset[6:0] == IO_TIMA) tima_d = data;
								if (dec.offset[6:0] == IO_TMA)  tma_d  = data;
								if (dec.offset[6:0] == IO_TAC)  tac_d  = data;
								if (dec.offset[6:0] == IO_IF)   if_d   = data;
							end
							if (address == DMA_ADDR) begin
								cnt_d   = '0;
								state_d = ST_DMA_RD;
							end
						end
						OP_TICK: state_d = ST_TICK_RD;
						default: begin
							req.wr_sel  = MEM_ROM;
							req.wr_addr = address[14:0];
							req.wr_data = data;
							req.wr_en   = address < 16'(ROM_BYTES);
							state_d     = ST_DONE;
						end
					endcase
				end
			end
			ST_READ: begin
				rd_d    = rdata;
				state_d = ST_DONE;
			end
			ST_DMA_RD: begin
				begin : dma_src
					decode_t ds;
					ds          = decode({data_q, cnt_q[7:0]});
					req.rd_sel  = ds.sel;
					req.rd_addr = ds.offset;
				end
				state_d = ST_DMA_WR;
			end
			ST_DMA_WR: begin
				req.wr_sel  = MEM_OAM;
				req.wr_addr = cnt_q;
				req.wr_data = rdata;
				req.wr_en   = 1'b1;
				cnt_d       = cnt_q + 15'd1;
				state_d     = (cnt_q[7:0] == DMA_LEN - 8'd1) ? ST_DONE : ST_DMA_RD;
			end
			ST_TICK_RD: begin
				div_cnt_d = div_sum[7:0];
				if (div_sum[8]) div_d = div_q + 8'd1;
				if (tac_q[2]) begin
					tim_cnt_d = tim_sum;
					state_d   = ST_TICK_STEP;
				end else begin
					state_d   = ST_TICK_WR;
				end
				cnt_d = '0;
			end
			ST_TICK_STEP: begin
				// one timer period per cycle; up to 67 steps after a switch to a faster rate
				if (tim_cnt_q >= period) begin
					tim_cnt_d = tim_cnt_q - period;
					if (tima_q == 8'hFF) begin
						tima_d = tma_q;
						if_d   = if_q | 8'h04;
					end else begin
						tima_d = tima_q + 8'd1;
					end
				end else begin
					state_d = ST_TICK_WR;
				end
			end
			ST_TICK_WR: begin
				// write timer registers back to io ram, one per cycle
				req.wr_en  = 1'b1;
				req.wr_sel = MEM_IO;
				unique case (cnt_q[1:0])
					2'd0: begin req.wr_addr = {8'd0, IO_DIV};  req.wr_data = div_q;  end
					2'd1: begin req.wr_addr = {8'd0, IO_TIMA}; req.wr_data = tima_q; end
					default: begin req.wr_addr = {8'd0, IO_IF}; req.wr_data = if_q; end
				endcase
				cnt_d = cnt_q + 15'd1;
				if (cnt_q[1:0] == 2'd2) state_d = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign read_data         = rd_q;
	assign timer_irq_pending = irq_q;

endmodule

>>> design/hmbt_clr.sv
// ----------------------------------------------------------------------------
// hmbt_clr
// clearing pass after reset: walks every ram index once, one entry a cycle
// ----------------------------------------------------------------------------
module hmbt_clr
	import hmbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	output logic        clearing,
	output logic [14:0] clr_addr,
	output logic [7:0]  clr_io_data
);

	logic        active_q;
	logic [14:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q) begin
			idx_q <= idx_q + 15'd1;
			if (idx_q == 15'(ROM_BYTES - 1)) active_q <= 1'b0;
		end
	end

	assign clearing    = active_q;
	assign clr_addr    = idx_q;
	assign clr_io_data = io_reset_value(idx_q[IO_AW-1:0]);

endmodule

>>> design/handheld_memory_bus_with_timer.sv
// ----------------------------------------------------------------------------
// handheld_memory_bus_with_timer
// handheld memory map with divider, timer and sprite dma
// ----------------------------------------------------------------------------
// Usage: raise start with op, address, data and cycles; the item is taken
// when start is high and busy is low. Exactly one result per item appears
// on read_data and timer_irq_pending with done high for one cycle.
// A read passes through a state that registers the ram data before done;
// a write or rom load goes to done directly. A tick adds cycles to the
// divider and, with the timer on, steps the counter one timer period per
// cycle (up to 67 steps after a switch to a faster rate); the tick then
// writes divider, counter and flags back to the io ram one per cycle. A
// dma write copies each sprite byte with a read and a write on the
// shared port. The next item is taken the cycle after done.
// Reset: a clearing pass walks all rams one entry a cycle, writing zero
// or the post-boot io value; busy stays high meanwhile.
// The receiver cannot stall; results are offered once.
// ----------------------------------------------------------------------------
module handheld_memory_bus_with_timer
	import hmbt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  op,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  logic [5:0]  cycles,
	output logic [7:0]  read_data,
	output logic        timer_irq_pending
);

	mem_req_t    ctrl_req;
	logic [7:0]  rdata;
	logic        clearing;
	logic [14:0] clr_addr;
	logic [7:0]  clr_io_data;

	hmbt_clr u_clr (
		.clk, .arst_n, .clearing, .clr_addr, .clr_io_data
	);

	hmbt_ctrl u_ctrl (
		.clk, .arst_n, .clearing, .start, .op, .address, .data, .cycles,
		.busy, .done, .read_data, .timer_irq_pending,
		.req(ctrl_req), .rdata
	);

	hmbt_mem u_mem (
		.clk, .arst_n, .req(ctrl_req), .clear(clearing), .clr_addr, .clr_io_data,
		.rdata
	);

endmodule

>>> design/hmbt_checker.sv
// ----------------------------------------------------------------------------
// hmbt_checker
// port-level checks on the command handshake and result strobe
// ----------------------------------------------------------------------------
module hmbt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [7:0] read_data
);

	// an accepted item makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after transfer");

	// a result strobe ends the item
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");

	// strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held");

	// strobe only while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result while idle");

	// result data is known when offered
	a_done_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(read_data)) else $error("unknown result data");

endmodule

bind handheld_memory_bus_with_timer hmbt_checker u_hmbt_checker (
	.clk, .arst_n, .start, .busy, .done, .read_data
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives bus reads, writes, ticks and rom loads into the memory bus block
// and compares every result against an in-bench model of the memory map,
// divider, timer and sprite dma
// ----------------------------------------------------------------------------
module tb_top
	import hmbt_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic [1:0]  op;
	logic [15:0] address;
	logic [7:0]  data;
	logic [5:0]  cycles;
	logic [7:0]  read_data;
	logic        timer_irq_pending;

	handheld_memory_bus_with_timer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.op(op), .address(address), .data(data), .cycles(cycles),
		.read_data(read_data), .timer_irq_pending(timer_irq_pending)
	);

	typedef struct {
		logic [7:0] rd;
		logic       irq;
	} bus_result_t;

	typedef struct {
		op_t         kind;
		logic [15:0] addr;
		logic [7:0]  val;
		logic [5:0]  cyc;
		bit          typed;
		logic [7:0]  rd;
		logic        irq;
	} stim_row_t;

	// model state
	logic [7:0] m_rom [ROM_BYTES];
	logic [7:0] m_vram [VRAM_BYTES];
	logic [7:0] m_eram [ERAM_BYTES];
	logic [7:0] m_wram [WRAM_BYTES];
	logic [7:0] m_oam [OAM_BYTES];
	logic [7:0] m_io [128];
	logic [7:0] m_hram [HRAM_BYTES];
	logic [7:0] m_ie;
	int unsigned div_cnt;
	int unsigned tim_cnt;

	bus_result_t expected_q[$];
	int errors;
	int mismatches;
	int idle_pct;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [7:0] map_read(input logic [15:0] a);
		if (a <= 16'h7FFF) return m_rom[a];
		if (a <= 16'h9FFF) return m_vram[a - 16'h8000];
		if (a <= 16'hBFFF) return m_eram[a - 16'hA000];
		if (a <= 16'hDFFF) return m_wram[a - 16'hC000];
		if (a <= 16'hFDFF) return m_wram[a - 16'hE000];
		if (a <= 16'hFE9F) return m_oam[a - 16'hFE00];
		if (a <= 16'hFEFF) return 8'hFF;
		if (a <= 16'hFF7F) return m_io[a[6:0]];
		if (a <= 16'hFFFE) return m_hram[a - 16'hFF80];
		return m_ie;
	endfunction

	function automatic void map_write(input logic [15:0] a, input logic [7:0] v);
		if (a == DIV_ADDR) begin
			m_io[IO_DIV] = 8'h00;
			div_cnt = 0;
		end else if (a == DMA_ADDR) begin
			m_io[DMA_ADDR[6:0]] = v;
			for (int i = 0; i < DMA_LEN; i++)
				m_oam[i] = map_read({v, 8'h00} + 16'(i));
		end else if (a <= 16'h7FFF) begin
		end else if (a <= 16'h9FFF) m_vram[a - 16'h8000] = v;
		else if (a <= 16'hBFFF) m_eram[a - 16'hA000] = v;
		else if (a <= 16'hDFFF) m_wram[a - 16'hC000] = v;
		else if (a <= 16'hFDFF) m_wram[a - 16'hE000] = v;
		else if (a <= 16'hFE9F) m_oam[a - 16'hFE00] = v;
		else if (a <= 16'hFEFF) begin
		end else if (a <= 16'hFF7F) m_io[a[6:0]] = v;
		else if (a <= 16'hFFFE) m_hram[a - 16'hFF80] = v;
		else m_ie = v;
	endfunction

	function automatic void timer_advance(input logic [5:0] cyc);
		int unsigned period;
		div_cnt += cyc;
		while (div_cnt >= 256) begin
			div_cnt -= 256;
			m_io[IO_DIV] = m_io[IO_DIV] + 8'd1;
		end
		if (m_io[IO_TAC][2]) begin
			case (m_io[IO_TAC][1:0])
				2'd1: period = 16;
				2'd2: period = 64;
				2'd3: period = 256;
				default: period = 1024;
			endcase
			tim_cnt += cyc;
			// a faster rate after a slow one may step several times here
			while (tim_cnt >= period) begin
				tim_cnt -= period;
				if (m_io[IO_TIMA] == 8'hFF) begin
					m_io[IO_TIMA] = m_io[IO_TMA];
					m_io[IO_IF][2] = 1'b1;
				end else begin
					m_io[IO_TIMA] = m_io[IO_TIMA] + 8'd1;
				end
			end
			tim_cnt &= 32'h3FF;
		end
	endfunction

	function automatic bus_result_t bus_predict(input op_t k, input logic [15:0] a,
		input logic [7:0] v, input logic [5:0] cyc);
		bus_result_t r;
		r.rd = 8'h00;
		case (k)
			OP_READ: r.rd = map_read(a);
			OP_WRITE: map_write(a, v);
			OP_TICK: timer_advance(cyc);
			default: if (a < ROM_BYTES) m_rom[a] = v;
		endcase
		r.irq = m_io[IO_IF][2];
		return r;
	endfunction

	task automatic bus_model_reset();
		foreach (m_rom[i]) m_rom[i] = 8'h00;
		foreach (m_vram[i]) m_vram[i] = 8'h00;
		foreach (m_eram[i]) m_eram[i] = 8'h00;
		foreach (m_wram[i]) m_wram[i] = 8'h00;
		foreach (m_oam[i]) m_oam[i] = 8'h00;
		foreach (m_hram[i]) m_hram[i] = 8'h00;
		foreach (m_io[i]) m_io[i] = 8'h00;
		m_io[IO_JOYP] = 8'hFF;
		m_io[IO_LCDC] = 8'h93;
		m_io[IO_BGP] = 8'hFC;
		m_io[IO_OBP0] = 8'hFF;
		m_io[IO_OBP1] = 8'hFF;
		m_io[IO_IF] = 8'hE1;
		m_ie = 8'h00;
		div_cnt = 0;
		tim_cnt = 0;
	endtask

	// one transfer: wait for the handshake, then drop start or idle
	task automatic send_item(input op_t k, input logic [15:0] a, input logic [7:0] v,
		input logic [5:0] cyc, input bit typed, input logic [7:0] trd, input logic trq);
		bus_result_t r;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= k;
		address <= a;
		data <= v;
		cycles <= cyc;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = bus_predict(k, a, v, cyc);
		if (typed && (r.rd !== trd || r.irq !== trq)) begin
			errors++;
			$display("model disagrees with table: op %0d addr %h", k, a);
		end
		expected_q.push_back(r);
		start <= 1'b0;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	always @(posedge clk) begin
		bus_result_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result rd %h", read_data);
			end else begin
				e = expected_q.pop_front();
				if (read_data !== e.rd || timer_irq_pending !== e.irq) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp rd %h irq %b, got rd %h irq %b",
							e.rd, e.irq, read_data, timer_irq_pending);
				end
			end
		end
	end

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(11))
			0: return 16'($urandom_range(16'h00FF));
			1: return 16'h8000 + 16'($urandom_range(16'h1FFF));
			2: return 16'hA000 + 16'($urandom_range(16'h1FFF));
			3: return 16'hC000 + 16'($urandom_range(16'h1FFF));
			4: return 16'hE000 + 16'($urandom_range(16'h1DFF));
			5: return 16'hFE00 + 16'($urandom_range(16'hFF));
			6: return 16'hFF00 + 16'($urandom_range(16'h7F));
			7: return 16'hFF80 + 16'($urandom_range(16'h7F));
			8: return 16'hFF04 + 16'($urandom_range(3));
			9: return 16'hFF0F;
			10: return 16'($urandom_range(16'hFFFF));
			default: return 16'hFFFF;
		endcase
	endfunction

	stim_row_t rows[$];

	initial begin
		op_t k;
		logic [15:0] a;
		logic [7:0] v;
		bit dma_ok;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_READ;
		address = 16'h0000;
		data = 8'h00;
		cycles = 6'd0;
		errors = 0;
		mismatches = 0;
		idle_pct = 0;
		bus_model_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		rows = '{
			'{OP_READ, 16'hFF00, 8'h00, 6'd0, 1, 8'hFF, 1'b0},
			'{OP_READ, 16'hFF40, 8'h00, 6'd0, 1, 8'h93, 1'b0},
			'{OP_READ, 16'hFF47, 8'h00, 6'd0, 1, 8'hFC, 1'b0},
			'{OP_READ, 16'hFF0F, 8'h00, 6'd0, 1, 8'hE1, 1'b0},
			'{OP_READ, 16'hFEA0, 8'h00, 6'd0, 1, 8'hFF, 1'b0},
			'{OP_READ, 16'hFEFF, 8'h00, 6'd0, 1, 8'hFF, 1'b0},
			'{OP_LOAD, 16'h7FFF, 8'hFF, 6'd0, 1, 8'h00, 1'b0},
			'{OP_LOAD, 16'h8000, 8'h55, 6'd0, 1, 8'h00, 1'b0},
			'{OP_READ, 16'h7FFF, 8'h00, 6'd0, 1, 8'hFF, 1'b0},
			'{OP_WRITE, 16'h0000, 8'hAA, 6'd0, 1, 8'h00, 1'b0},
			'{OP_WRITE, 16'hFEA5, 8'hAA, 6'd0, 1, 8'h00, 1'b0},
			'{OP_WRITE, 16'hDFFF, 8'h5A, 6'd0, 1, 8'h00, 1'b0},
			'{OP_READ, 16'hFDFF, 8'h00, 6'd0, 0, 8'h00, 1'b0},
			'{OP_WRITE, 16'hFFFF, 8'hFF, 6'd0, 0, 8'h00, 1'b0},
			'{OP_READ, 16'hFFFF, 8'h00, 6'd0, 1, 8'hFF, 1'b0},
			'{OP_WRITE, 16'hFF46, 8'h7F, 6'd0, 0, 8'h00, 1'b0},
			'{OP_READ, 16'hFE9F, 8'h00, 6'd0, 1, 8'h00, 1'b0},
			'{OP_TICK, 16'h0000, 8'h00, 6'd63, 0, 8'h00, 1'b0},
			'{OP_WRITE, 16'hFF05, 8'hFF, 6'd0, 0, 8'h00, 1'b0},
			'{OP_WRITE, 16'hFF06, 8'hA5, 6'd0, 0, 8'h00, 1'b0},
			'{OP_WRITE, 16'hFF07, 8'h05, 6'd0, 0, 8'h00, 1'b0},
			'{OP_TICK, 16'h0000, 8'h00, 6'd16, 0, 8'h00, 1'b0},
			'{OP_READ, 16'hFF05, 8'h00, 6'd0, 1, 8'hA5, 1'b1},
			'{OP_WRITE, 16'hFF04, 8'h77, 6'd0, 0, 8'h00, 1'b1},
			'{OP_READ, 16'hFF04, 8'h00, 6'd0, 1, 8'h00, 1'b1}
		};
		foreach (rows[i])
			send_item(rows[i].kind, rows[i].addr, rows[i].val, rows[i].cyc,
				rows[i].typed, rows[i].rd, rows[i].irq);

		for (int n = 0; n < 500; n++) begin
			case (n / 125)
				0: idle_pct = 0;
				1: idle_pct = 59;
				2: idle_pct = 14;
				default: idle_pct = (n % 50 < 25) ? 0 : 59;
			endcase
			k = op_t'($urandom_range(3));
			a = pick_addr();
			v = 8'($urandom_range(255));
			// keep dma rare: each one copies every sprite byte through the shared port
			dma_ok = ($urandom_range(19) == 0);
			if (k == OP_WRITE && a == DMA_ADDR && !dma_ok) a = 16'hFF45;
			if (k == OP_WRITE && a == 16'hFF07) v = {5'($urandom_range(31)), 3'($urandom_range(7))};
			if (k == OP_WRITE && a == 16'hFF0F && $urandom_range(1)) v[2] = 1'b0;
			if (k == OP_LOAD && $urandom_range(3) != 0) a = {1'b0, a[14:0]};
			send_item(k, a, v, 6'($urandom_range(63)), 0, 8'h00, 1'b0);
		end

		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
